// ===== hdl/swmhr_pkg.sv =====
package swmhr_pkg;

  // stack geometry
  localparam int DEPTH  = 16;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // command codes
  localparam logic [2:0] CMD_PUSH    = 3'd0;
  localparam logic [2:0] CMD_POP     = 3'd1;
  localparam logic [2:0] CMD_PEEK    = 3'd2;
  localparam logic [2:0] CMD_MIDDLE  = 3'd3;
  localparam logic [2:0] CMD_REVERSE = 3'd4;
  localparam logic [2:0] CMD_DUMP    = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

// ===== hdl/swmhr_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
module swmhr_ram #(
  parameter int WIDTH = 32,
  parameter int NUM   = 16,
  parameter int ADDR  = $clog2(NUM)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ADDR-1:0]  waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [ADDR-1:0]  raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [NUM];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/stack_with_middle_and_half_reverse_core.sv =====
// Fixed-depth stack of signed 32-bit words, one command per request. A request
// is taken when start is high and busy is low; each result shows on status,
// data and last for exactly one cycle with strobe high, and the receiver
// cannot hold it off. Push, pop, peek and middle give one result each: the
// entry store is a single RAM with one read and one write port, and a read
// result appears the cycle after the request, while the next request may
// already be taken. Dump holds busy while it reads and streams count
// results on consecutive cycles, top entry first, last set on the bottom one.
// Reverse-bottom-half reports its status the cycle after the request, then
// holds busy while it swaps floor(floor(count/2)/2) pairs, each in order:
// read low, read high, write low, write high through the same RAM ports.
// Pop, peek, middle, reverse and dump on an empty stack return status empty;
// push on a full stack returns status full. Codes 6 and 7 are taken and ignored.
// No clearing pass after reset: only entries below count are ever read.
module stack_with_middle_and_half_reverse_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] push_value,
  output logic               strobe,
  output logic [1:0]         status,
  output logic signed [31:0] data,
  output logic               last
);

  localparam int AW = swmhr_pkg::AW;
  localparam int CW = swmhr_pkg::CW;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DUMP  = 6'b000010,
    S_REV_A = 6'b000100,  // read low entry
    S_REV_B = 6'b001000,  // read high entry, low arrives
    S_REV_C = 6'b010000,  // high arrives, write it low
    S_REV_D = 6'b100000   // write saved low entry high
  } state_t;

  state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic [AW-1:0] ptr, ptr_next;      // dump read pointer
  logic [AW-1:0] ri, ri_next;        // reverse low index
  logic [AW-1:0] rj, rj_next;        // reverse high index
  logic [31:0]   tmp, tmp_next;      // saved low entry during a swap

  // read result goes out next cycle
  logic          rd_pend, rd_pend_next;
  logic          rd_last, rd_last_next;
  // result with no RAM data (push, reverse, empty, full)
  logic          imm_strobe, imm_strobe_next;
  logic [1:0]    imm_status, imm_status_next;

  // RAM ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  logic          accept;
  logic          empty;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] mid;
  logic [CW-1:0] half;

  assign accept   = start && (state == S_IDLE);
  assign empty    = (count == '0);
  assign count_m1 = count - CW'(1);
  assign mid      = count_m1 >> 1;
  assign half     = count >> 1;

  swmhr_ram #(
    .WIDTH(swmhr_pkg::DATA_W),
    .NUM  (swmhr_pkg::DEPTH),
    .ADDR (AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    ri_next         = ri;
    rj_next         = rj;
    tmp_next        = tmp;
    rd_pend_next    = 1'b0;
    rd_last_next    = 1'b0;
    imm_strobe_next = 1'b0;
    imm_status_next = swmhr_pkg::ST_OK;
    we              = 1'b0;
    waddr           = '0;
    wdata           = '0;
    raddr           = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            swmhr_pkg::CMD_PUSH: begin
              imm_strobe_next = 1'b1;
              if (count == CW'(swmhr_pkg::DEPTH)) begin
                imm_status_next = swmhr_pkg::ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = count[AW-1:0];
                wdata      = push_value;
                count_next = count + CW'(1);
              end
            end
            swmhr_pkg::CMD_POP, swmhr_pkg::CMD_PEEK: begin
              if (empty) begin
                imm_strobe_next = 1'b1;
                imm_status_next = swmhr_pkg::ST_EMPTY;
              end else begin
                raddr        = count_m1[AW-1:0];
                rd_pend_next = 1'b1;
                rd_last_next = 1'b1;
                if (cmd == swmhr_pkg::CMD_POP) begin
                  count_next = count_m1;
                end
              end
            end
            swmhr_pkg::CMD_MIDDLE: begin
              if (empty) begin
                imm_strobe_next = 1'b1;
                imm_status_next = swmhr_pkg::ST_EMPTY;
              end else begin
                raddr        = mid[AW-1:0];
                rd_pend_next = 1'b1;
                rd_last_next = 1'b1;
              end
            end
            swmhr_pkg::CMD_REVERSE: begin
              imm_strobe_next = 1'b1;
              if (empty) begin
                imm_status_next = swmhr_pkg::ST_EMPTY;
              end else if (half >= CW'(2)) begin
                ri_next    = '0;
                rj_next    = half[AW-1:0] - AW'(1);
                state_next = S_REV_A;
              end
            end
            swmhr_pkg::CMD_DUMP: begin
              if (empty) begin
                imm_strobe_next = 1'b1;
                imm_status_next = swmhr_pkg::ST_EMPTY;
              end else begin
                // first read issued now, top of stack
                raddr        = count_m1[AW-1:0];
                rd_pend_next = 1'b1;
                rd_last_next = (count == CW'(1));
                if (count != CW'(1)) begin
                  ptr_next   = count_m1[AW-1:0] - AW'(1);
                  state_next = S_DUMP;
                end
              end
            end
            default: begin
              // unused codes: no result
            end
          endcase
        end
      end
      S_DUMP: begin
        raddr        = ptr;
        rd_pend_next = 1'b1;
        rd_last_next = (ptr == '0);
        if (ptr == '0) begin
          state_next = S_IDLE;
        end else begin
          ptr_next = ptr - AW'(1);
        end
      end
      S_REV_A: begin
        raddr      = ri;
        state_next = S_REV_B;
      end
      S_REV_B: begin
        raddr      = rj;
        tmp_next   = rdata;
        state_next = S_REV_C;
      end
      S_REV_C: begin
        we         = 1'b1;
        waddr      = ri;
        wdata      = rdata;
        state_next = S_REV_D;
      end
      S_REV_D: begin
        we    = 1'b1;
        waddr = rj;
        wdata = tmp;
        // another pair while the indices have not met
        if (({1'b0, ri} + (AW + 1)'(2)) < {1'b0, rj}) begin
          ri_next    = ri + AW'(1);
          rj_next    = rj - AW'(1);
          state_next = S_REV_A;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rd_pend    <= 1'b0;
      imm_strobe <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      rd_pend    <= rd_pend_next;
      imm_strobe <= imm_strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    ri         <= ri_next;
    rj         <= rj_next;
    tmp        <= tmp_next;
    rd_last    <= rd_last_next;
    imm_status <= imm_status_next;
  end

  // read and immediate results never land in the same cycle
  assign busy   = (state != S_IDLE);
  assign strobe = rd_pend || imm_strobe;
  assign status = rd_pend ? swmhr_pkg::ST_OK : imm_status;
  assign data   = rd_pend ? rdata : '0;
  assign last   = rd_pend ? rd_last : 1'b1;

endmodule

// ===== hdl/swmhr_checker.sv =====
module swmhr_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [2:0]         cmd,
  input logic               strobe,
  input logic [1:0]         status,
  input logic signed [31:0] data,
  input logic               last
);

  logic accept;
  assign accept = start && !busy;

  // single-result commands answer on the next cycle
  a_single_next: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == swmhr_pkg::CMD_PUSH || cmd == swmhr_pkg::CMD_POP ||
               cmd == swmhr_pkg::CMD_PEEK || cmd == swmhr_pkg::CMD_MIDDLE ||
               cmd == swmhr_pkg::CMD_REVERSE) |=> strobe && last)
    else $error("single-result request did not answer next cycle");

  // unused codes give nothing
  a_unused_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd > swmhr_pkg::CMD_DUMP) |=> !strobe)
    else $error("result for an unused command code");

  // error status is a lone result with zero data
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    strobe && status != swmhr_pkg::ST_OK |-> last && data == '0)
    else $error("error status with data or without last");

  // dump results stream without gaps
  a_dump_stream: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside a dump");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !strobe)
    else $error("not idle after reset");

endmodule

bind stack_with_middle_and_half_reverse_core swmhr_checker u_swmhr_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .cmd       (cmd),
  .strobe    (strobe),
  .status    (status),
  .data      (data),
  .last      (last)
);
